/* rtl/lpg_pkg.sv */
// shared constants, types and state encoding for the line point generator
package lpg_pkg;

  // integer coordinate width and fraction bits of the computed coordinate
  localparam int COORD_BITS = 6;
  localparam int FRAC_BITS  = 8;

  // width of one fixed-point output coordinate
  localparam int FIX_W = COORD_BITS + FRAC_BITS;

  // stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * FIX_W + 7) / 8) * 8;

  // signed accumulator width, with headroom for one step past either end
  localparam int ACC_W = FIX_W + 2;

  // one quotient bit per divider step
  localparam int DIV_STEPS = FIX_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_FIX,
    ST_EMIT,
    ST_EMPTY
  } lpg_state_e;

  typedef struct packed {
    logic capture;
    logic setup;
    logic div_step;
    logic div_fix;
    logic emit_point;
    logic emit_empty;
  } lpg_cmd_t;

  typedef struct packed {
    logic empty;
    logic div_last;
    logic point_last;
    logic out_free;
  } lpg_status_t;

endpackage

/* rtl/lpg_ctrl.sv */
// sequencing state machine: capture, slope division, point emission
module lpg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lpg_pkg::lpg_status_t status_i,
  output lpg_pkg::lpg_cmd_t    cmd_o
);

  lpg_pkg::lpg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpg_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lpg_pkg::ST_SETUP;
      end
      lpg_pkg::ST_SETUP: begin
        if (status_i.empty) state_d = lpg_pkg::ST_EMPTY;
        else                state_d = lpg_pkg::ST_DIV;
      end
      lpg_pkg::ST_DIV: begin
        if (status_i.div_last) state_d = lpg_pkg::ST_FIX;
      end
      lpg_pkg::ST_FIX: begin
        state_d = lpg_pkg::ST_EMIT;
      end
      lpg_pkg::ST_EMIT: begin
        if (status_i.out_free && status_i.point_last) state_d = lpg_pkg::ST_IDLE;
      end
      lpg_pkg::ST_EMPTY: begin
        if (status_i.out_free) state_d = lpg_pkg::ST_IDLE;
      end
      default: begin
        state_d = lpg_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lpg_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      lpg_pkg::ST_SETUP: begin
        cmd_o.setup = !status_i.empty;
      end
      lpg_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      lpg_pkg::ST_FIX: begin
        cmd_o.div_fix = 1'b1;
      end
      lpg_pkg::ST_EMIT: begin
        cmd_o.emit_point = status_i.out_free;
      end
      lpg_pkg::ST_EMPTY: begin
        cmd_o.emit_empty = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* rtl/lpg_datapath.sv */
// segment setup, serial slope divider, minor-axis stepper and output register
module lpg_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [lpg_pkg::IN_DATA_W-1:0]      in_data_i,
  input  lpg_pkg::lpg_cmd_t                  cmd_i,
  output lpg_pkg::lpg_status_t               status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lpg_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                               out_last_o,
  output logic                               out_empty_o
);

  localparam int C = lpg_pkg::COORD_BITS;
  localparam int F = lpg_pkg::FRAC_BITS;
  localparam int W = lpg_pkg::FIX_W;
  localparam int A = lpg_pkg::ACC_W;

  // endpoint decode
  logic [C-1:0] x1, y1, x2, y2;
  logic [C-1:0] adx, ady, d_c, lo_c, m0_c, mh_c, mabs_c, lastk_c;
  logic         x_major, mneg_c, empty_c, lo_first;

  assign x1 = in_data_i[C-1:0];
  assign y1 = in_data_i[2*C-1:C];
  assign x2 = in_data_i[3*C-1:2*C];
  assign y2 = in_data_i[4*C-1:3*C];

  always_comb begin
    adx     = (x1 > x2) ? (x1 - x2) : (x2 - x1);
    ady     = (y1 > y2) ? (y1 - y2) : (y2 - y1);
    x_major = adx > ady;
    if (x_major) begin
      lo_first = x1 < x2;
      d_c      = adx;
      lo_c     = lo_first ? x1 : x2;
      m0_c     = lo_first ? y1 : y2;
      mh_c     = lo_first ? y2 : y1;
    end else begin
      lo_first = y1 < y2;
      d_c      = ady;
      lo_c     = lo_first ? y1 : y2;
      m0_c     = lo_first ? x1 : x2;
      mh_c     = lo_first ? x2 : x1;
    end
    mneg_c  = mh_c < m0_c;
    mabs_c  = mneg_c ? (m0_c - mh_c) : (mh_c - m0_c);
    empty_c = !x_major && (ady == '0);
    // x-major includes the upper end, y-major stops one short of it
    lastk_c = x_major ? d_c : C'(d_c - 1'b1);
  end

  // segment registers
  logic         xmaj_q, mneg_q, empty_q;
  logic [C-1:0] d_q, lo_q, m0_q, mabs_q, lastk_q;

  // divider registers
  logic [C-1:0]                  rem_q;
  logic [W-1:0]                  quo_q;
  logic [lpg_pkg::DIV_CNT_W-1:0] cnt_q;

  // stepper registers: acc holds the rounded minor value, res the residue below 2d
  logic signed [A-1:0] acc_q, qs_q;
  logic [C:0]          res_q, rs_q;
  logic [C-1:0]        k_q, v_q;

  // output register
  logic         out_valid_q, out_last_q, out_empty_q;
  logic [W-1:0] px_q, py_q;

  // divider step
  logic [C:0]   trial;
  logic         ge;
  logic [C-1:0] rem_step;
  assign trial    = {rem_q, quo_q[W-1]};
  assign ge       = trial >= {1'b0, d_q};
  assign rem_step = ge ? C'(trial - {1'b0, d_q}) : trial[C-1:0];

  // signed step from the unsigned quotient, with residue kept in [0, 2d)
  logic signed [A-1:0] qu_s, qs_c;
  logic [C:0]          d2, rem2, rs_c;
  assign qu_s = $signed({2'b00, quo_q});
  assign d2   = {d_q, 1'b0};
  assign rem2 = {rem_q, 1'b0};

  always_comb begin
    if (!mneg_q) begin
      qs_c = qu_s;
      rs_c = rem2;
    end else if (rem_q == '0) begin
      qs_c = -qu_s;
      rs_c = '0;
    end else begin
      qs_c = -qu_s - A'(1);
      rs_c = d2 - rem2;
    end
  end

  // minor-axis advance
  logic [C+1:0]        rsum;
  logic                wrap;
  logic [C:0]          res_next;
  logic signed [A-1:0] acc_next;
  assign rsum     = {1'b0, res_q} + {1'b0, rs_q};
  assign wrap     = rsum >= {1'b0, d2};
  assign res_next = wrap ? (C+1)'(rsum - {1'b0, d2}) : rsum[C:0];
  assign acc_next = acc_q + qs_q + $signed({{(A-1){1'b0}}, wrap});

  // current point
  logic [W-1:0] major_fix, minor_fix;
  assign major_fix = W'(v_q) << F;
  assign minor_fix = acc_q[W-1:0];

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_point || cmd_i.emit_empty) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      xmaj_q  <= x_major;
      mneg_q  <= mneg_c;
      empty_q <= empty_c;
      d_q     <= d_c;
      lo_q    <= lo_c;
      m0_q    <= m0_c;
      mabs_q  <= mabs_c;
      lastk_q <= lastk_c;
    end
    if (cmd_i.setup) begin
      quo_q <= W'(mabs_q) << F;
      rem_q <= '0;
      cnt_q <= '0;
      acc_q <= $signed(A'(m0_q) << F);
      res_q <= {1'b0, d_q};
      k_q   <= '0;
      v_q   <= lo_q;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_step;
      quo_q <= {quo_q[W-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.div_fix) begin
      qs_q <= qs_c;
      rs_q <= rs_c;
    end
    if (cmd_i.emit_point) begin
      px_q        <= xmaj_q ? major_fix : minor_fix;
      py_q        <= xmaj_q ? minor_fix : major_fix;
      out_last_q  <= k_q == lastk_q;
      out_empty_q <= 1'b0;
      acc_q       <= acc_next;
      res_q       <= res_next;
      k_q         <= k_q + 1'b1;
      v_q         <= v_q + 1'b1;
    end
    if (cmd_i.emit_empty) begin
      px_q        <= '0;
      py_q        <= '0;
      out_last_q  <= 1'b1;
      out_empty_q <= 1'b1;
    end
  end

  assign status_o.empty      = empty_q;
  assign status_o.div_last   = cnt_q == lpg_pkg::DIV_CNT_W'(lpg_pkg::DIV_STEPS - 1);
  assign status_o.point_last = k_q == lastk_q;
  assign status_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = lpg_pkg::OUT_DATA_W'({py_q, px_q});
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;

endmodule

/* rtl/line_point_generator_top.sv */
// top level of the line point generator: stream ports, controller and datapath
//
// Takes one segment word with two integer endpoints and streams out the points
// on it, one word per step of the major axis, starting at the lower end of that
// axis. When |dx| > |dy| x is the major axis and both ends are included;
// otherwise y is the major axis and the upper end is left out. The other
// coordinate is the exact line value rounded to the nearest 1/256 with ties
// going up, and vertical segments keep x at the endpoint value. A segment that
// gives no points (both endpoints equal) yields one word with tuser set, zero
// coordinates and tlast set. Sequence: a segment is taken when the block is
// idle; then a setup step, a serial slope divider that makes one quotient bit
// per cycle, one for each coordinate and fraction bit, a sign correction step,
// then one point per cycle while the output side takes them. An empty segment
// goes from setup straight to its marker word. After the divider the next
// point value comes from an add and a compare on the residue, never from
// another division. The output word sits in a register, so the next
// segment is accepted while the last point of the previous one still waits
// to be taken.
module line_point_generator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // segment words
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // from bit 0: first_x, first_y, second_x, second_y
  input  logic [lpg_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // point words
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // from bit 0: point_x, point_y, zero padding
  output logic [lpg_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // last_point: final word of this segment
  output logic                              m_axis_tlast_o,
  // from bit 0: empty_run
  output logic                              m_axis_tuser_o
);

  // command and status between controller and datapath
  lpg_pkg::lpg_cmd_t    cmd;
  lpg_pkg::lpg_status_t status;

  lpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // setup, divider, stepper and the output register
  lpg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_empty_o (m_axis_tuser_o)
  );

endmodule

/* rtl/lpg_checker.sv */
// port-level checks for the line point generator, bound to the top level
module lpg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [lpg_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [lpg_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tlast_o,
  input logic                           m_axis_tuser_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled output word changed");

  // an empty-segment word is alone and carries zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("empty word malformed");

  // one segment at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("segment accepted while busy");

  // no new segment while points of the current one are still pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready before last point was produced");

endmodule

bind line_point_generator_top lpg_checker u_lpg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* tb/line_point_generator_top_test.sv */
// self-checking testbench for the line point generator stream top level
module line_point_generator_top_test;

  localparam int COORD_BITS = lpg_pkg::COORD_BITS;
  localparam int FRAC_BITS  = lpg_pkg::FRAC_BITS;
  localparam int FIX_W      = lpg_pkg::FIX_W;
  localparam int IN_DATA_W  = lpg_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = lpg_pkg::OUT_DATA_W;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_SEGMENTS = 210;

  // one point word as the block should send it
  typedef struct packed {
    logic             empty_run;
    logic             last_point;
    logic [FIX_W-1:0] point_y;
    logic [FIX_W-1:0] point_x;
  } point_t;

  // predicts the points of each accepted segment and checks the point words
  class segment_checker;
    point_t expected_points[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    task report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // queue one predicted word behind the others
    function void add_expected(point_t p);
      expected_points.insert(expected_points.size(), p);
    endfunction

    // base + off * num / den rounded to the nearest fraction step, ties up
    function logic [FIX_W-1:0] on_line_coord(longint base, longint off,
                                             longint num, longint den);
      longint n;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      n = (base * den + off * num) * (longint'(1) << FRAC_BITS);
      if (n < 0) n = 0;
      return FIX_W'((2 * n + den) / (2 * den));
    endfunction

    function void note_segment(logic [COORD_BITS-1:0] ax, logic [COORD_BITS-1:0] ay,
                               logic [COORD_BITS-1:0] bx, logic [COORD_BITS-1:0] by);
      longint x1, y1, x2, y2, dx, dy, adx, ady, lo, hi, v;
      point_t p;
      int     count;
      x1 = ax; y1 = ay; x2 = bx; y2 = by;
      dx = x2 - x1;
      dy = y2 - y1;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      count = 0;
      if (adx > ady) begin
        // x major, both ends included
        lo = x1 < x2 ? x1 : x2;
        hi = x1 < x2 ? x2 : x1;
        for (v = lo; v <= hi; v++) begin
          p.point_x    = FIX_W'(v << FRAC_BITS);
          p.point_y    = on_line_coord(y1, v - x1, dy, dx);
          p.last_point = (v == hi);
          p.empty_run  = 1'b0;
          add_expected(p);
          count++;
        end
      end else begin
        // y major, upper end left out
        lo = y1 < y2 ? y1 : y2;
        hi = y1 < y2 ? y2 : y1;
        for (v = lo; v < hi; v++) begin
          p.point_y = FIX_W'(v << FRAC_BITS);
          // vertical segment keeps x at the endpoint
          if (dx == 0) p.point_x = FIX_W'(x1 << FRAC_BITS);
          else p.point_x = on_line_coord(x1, v - y1, dx, dy);
          p.last_point = (v == hi - 1);
          p.empty_run  = 1'b0;
          add_expected(p);
          count++;
        end
      end
      // coincident endpoints give a single empty marker word
      if (count == 0) begin
        p = '0;
        p.last_point = 1'b1;
        p.empty_run  = 1'b1;
        add_expected(p);
      end
    endfunction

    task check_point(input point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        report($sformatf("point word with none expected: x=%0d y=%0d", got.point_x,
                         got.point_y));
      end else begin
        want = expected_points.pop_front();
        if (got.point_x !== want.point_x)
          report($sformatf("point_x got %0d want %0d", got.point_x, want.point_x));
        if (got.point_y !== want.point_y)
          report($sformatf("point_y got %0d want %0d", got.point_y, want.point_y));
        if (got.last_point !== want.last_point)
          report($sformatf("last_point got %b want %b", got.last_point, want.last_point));
        if (got.empty_run !== want.empty_run)
          report($sformatf("empty_run got %b want %b", got.empty_run, want.empty_run));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // from bit 0: first_x, first_y, second_x, second_y
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // from bit 0: point_x, point_y, zero padding
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // last_point
  logic                  m_axis_tlast;
  // empty_run
  logic                  m_axis_tuser;

  segment_checker checker_h;
  bit             steady;      // no idling on either side while set
  int             hold_cycles; // receiver hold-off still to run
  int             cycle_count;

  line_point_generator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  // 10 unit clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("line_point_generator_top verification failed");
      $finish;
    end
  end

  // receiver: random stalls, a counted hold-off on request, none while steady
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 24);
    end
  end

  // every point word taken is checked against the oldest prediction
  always @(posedge clk_i) begin
    point_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.point_x    = m_axis_tdata[FIX_W-1:0];
      got.point_y    = m_axis_tdata[2*FIX_W-1:FIX_W];
      got.last_point = m_axis_tlast;
      got.empty_run  = m_axis_tuser;
      checker_h.check_point(got);
    end
  end

  // offer one segment word, with a random gap first, and wait for it to be taken
  task automatic send_segment(input logic [COORD_BITS-1:0] ax, input logic [COORD_BITS-1:0] ay,
                              input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 24) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({by, bx, ay, ax});
    do @(posedge clk_i); while (!s_axis_tready);
    checker_h.note_segment(ax, ay, bx, by);
  endtask

  // sender pause until every predicted point has come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (checker_h.expected_points.size() != 0) @(posedge clk_i);
  endtask

  // random coordinate over the full range
  function automatic logic [COORD_BITS-1:0] rnd_coord();
    return COORD_BITS'($urandom_range(63));
  endfunction

  // endpoint near a given one, clipped to the coordinate range
  function automatic logic [COORD_BITS-1:0] near(logic [COORD_BITS-1:0] c);
    int t;
    t = int'(c) + int'($urandom_range(16)) - 8;
    if (t < 0) t = 0;
    if (t > 63) t = 63;
    return COORD_BITS'(t);
  endfunction

  initial begin
    logic [COORD_BITS-1:0] ax, ay, bx, by;
    int kind;
    checker_h     = new();
    steady        = 1'b0;
    hold_cycles   = 0;
    cycle_count   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: degenerate, axis aligned both ways, diagonals, extremes, shortest runs
    send_segment(0, 0, 0, 0);
    send_segment(63, 63, 63, 63);
    send_segment(0, 0, 63, 0);
    send_segment(63, 63, 0, 63);
    send_segment(5, 0, 5, 63);
    send_segment(58, 63, 58, 0);
    send_segment(0, 0, 63, 63);
    send_segment(63, 63, 0, 0);
    send_segment(0, 63, 63, 0);
    send_segment(63, 0, 0, 63);
    send_segment(0, 0, 63, 62);
    send_segment(0, 0, 62, 63);
    send_segment(63, 1, 0, 0);
    send_segment(1, 2, 3, 2);
    send_segment(0, 0, 1, 0);
    send_segment(0, 0, 0, 1);
    send_segment(0, 0, 1, 1);
    send_segment(10, 20, 13, 21);
    send_segment(40, 7, 33, 30);
    send_segment(21, 42, 42, 21);
    wait_drained();

    // receiver holds off long while the sender keeps offering, so the input stalls
    hold_cycles = 300;
    for (int i = 0; i < 6; i++)
      send_segment(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());

    for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
      // a stretch with no idling on either side
      steady = (i >= 90 && i < 130);
      kind = $urandom_range(99);
      ax = rnd_coord();
      ay = rnd_coord();
      if (kind < 55) begin
        // short segments keep the run fast
        bx = near(ax);
        by = near(ay);
      end else if (kind < 85) begin
        bx = rnd_coord();
        by = rnd_coord();
      end else if (kind < 93) begin
        // axis aligned
        if ($urandom_range(1)) begin
          bx = ax;
          by = rnd_coord();
        end else begin
          bx = rnd_coord();
          by = ay;
        end
      end else begin
        bx = ax;
        by = ay;
      end
      send_segment(ax, ay, bx, by);
    end
    steady = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (checker_h.expected_points.size() != 0)
      checker_h.report($sformatf("%0d point words never came",
                                 checker_h.expected_points.size()));
    if (checker_h.errors == 0) begin
      $display("line_point_generator_top verification clean");
    end else begin
      $display("line_point_generator_top verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lpg_pkg.sv
rtl/lpg_ctrl.sv
rtl/lpg_datapath.sv
rtl/line_point_generator_top.sv
rtl/lpg_checker.sv
tb/line_point_generator_top_test.sv
